### hw/rtl/meai_pkg.sv
`timescale 1ns / 1ps
package meai_pkg;
    localparam int NODE_COUNT = 1024;
    localparam int MAX_DEGREE = 16;
    localparam int NODE_W     = 10;
    localparam int DEG_W      = $clog2(MAX_DEGREE);
    localparam int CNT_W      = DEG_W + 1;
    localparam int EDGE_W     = 14;
    localparam int STAT_W     = 2;
    localparam int SUM_W      = EDGE_W + 1;
    localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};
    localparam int IDS_DEPTH  = NODE_COUNT * MAX_DEGREE;
    localparam int IDS_AW     = $clog2(IDS_DEPTH);
    localparam int CNTW_W     = 2 * CNT_W;

    localparam logic       OP_INSERT = 1'b0;
    localparam logic       OP_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
endpackage

### hw/rtl/meai_ram.sv
`timescale 1ns / 1ps
module meai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/mesh_edge_adjacency_index_unit.sv
`timescale 1ns / 1ps
// Mesh edge adjacency index.
// Input stream (s_axis): one transaction per item. tuser carries the operation
// (0 insert edge, 1 query edge number); tdata carries node_a and node_b.
// Output stream (m_axis): exactly one transaction per item, tdata carries
// edge_number and status (0 ok, 1 not found, 2 neighbour set full).
// A sequencer drives one compare/add datapath over two single-port-read RAMs:
// the neighbour id rows (16 ids per node) and a per-node word holding the set
// size and the count of higher-numbered neighbours.
// Insert: a scan of the id row, then a shift of the larger ids, for each of
// the two adds.
// Query: row scan of lo, then one counts RAM read per cycle over all nodes
// below lo.
// s_axis_tready is high only between items.
// After reset the counts RAM is cleared one word per cycle, during which no
// item is accepted. A finished result waits in the output register
// while the receiver stalls; the next item may be accepted meanwhile, but its
// result is held back until the register frees.
module mesh_edge_adjacency_index_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [9:0] node_a, [19:10] node_b, zero pad
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [13:0] edge_number, [15:14] status
);
    import meai_pkg::*;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_CRD   = 11'b00000000100,
        S_CWT   = 11'b00000001000,
        S_SRD   = 11'b00000010000,
        S_SCHK  = 11'b00000100000,
        S_SHRD  = 11'b00001000000,
        S_SHCHK = 11'b00010000000,
        S_CWR   = 11'b00100000000,
        S_SUM   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [NODE_W-1:0] r_lo, n_lo, r_hi, n_hi, r_node, n_node, r_id, n_id, r_k, n_k;
    logic              r_op, n_op, r_phase, n_phase, r_full, n_full, r_sv, n_sv;
    logic [CNT_W-1:0]  r_n, n_n, r_up, n_up, r_i, n_i, r_j, n_j;
    logic [DEG_W-1:0]  r_rank, n_rank;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic [NODE_W-1:0] r_clr, n_clr;

    logic                r_ovalid, n_ovalid;
    logic [EDGE_W-1:0]   r_onum, n_onum;
    logic [STAT_W-1:0]   r_ost, n_ost;

    logic                ids_we;
    logic [IDS_AW-1:0]   ids_waddr, ids_raddr;
    logic [NODE_W-1:0]   ids_wdata, ids_rdata;
    logic                cnt_we;
    logic [NODE_W-1:0]   cnt_waddr, cnt_raddr;
    logic [CNTW_W-1:0]   cnt_wdata, cnt_rdata;

    logic [NODE_W-1:0]   in_a, in_b;
    logic                in_op;
    logic [SUM_W:0]      sum_add;
    logic                last_add;

    assign in_a  = s_axis_tdata[NODE_W-1:0];
    assign in_b  = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign in_op = s_axis_tuser[0];

    meai_ram #(.WIDTH(NODE_W), .DEPTH(IDS_DEPTH)) u_ids (
        .i_clk   (i_clk),
        .i_we    (ids_we),
        .i_waddr (ids_waddr),
        .i_wdata (ids_wdata),
        .i_raddr (ids_raddr),
        .o_rdata (ids_rdata)
    );

    meai_ram #(.WIDTH(CNTW_W), .DEPTH(NODE_COUNT)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ost, r_onum};

    assign sum_add  = {1'b0, r_sum} + {{(SUM_W+1-CNT_W){1'b0}}, cnt_rdata[CNTW_W-1:CNT_W]};
    assign last_add = r_phase || (r_lo == r_hi);

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_node   = r_node;
        n_id     = r_id;
        n_k      = r_k;
        n_op     = r_op;
        n_phase  = r_phase;
        n_full   = r_full;
        n_sv     = r_sv;
        n_n      = r_n;
        n_up     = r_up;
        n_i      = r_i;
        n_j      = r_j;
        n_rank   = r_rank;
        n_sum    = r_sum;
        n_stat   = r_stat;
        n_clr    = r_clr;
        n_ovalid = r_ovalid & ~m_axis_tready;
        n_onum   = r_onum;
        n_ost    = r_ost;

        ids_we    = 1'b0;
        ids_waddr = {r_node, r_j[DEG_W-1:0]};
        ids_wdata = r_id;
        ids_raddr = {r_node, r_i[DEG_W-1:0]};
        cnt_we    = 1'b0;
        cnt_waddr = r_node;
        cnt_wdata = {(r_up + CNT_W'(r_id > r_node)), (r_n + CNT_W'(1))};
        cnt_raddr = r_node;

        unique case (r_state)
            S_CLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                n_clr     = r_clr + NODE_W'(1);
                if (r_clr == NODE_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = in_op;
                    n_lo    = (in_a < in_b) ? in_a : in_b;
                    n_hi    = (in_a < in_b) ? in_b : in_a;
                    n_node  = n_lo;
                    n_id    = n_hi;
                    n_phase = 1'b0;
                    n_full  = 1'b0;
                    n_rank  = '0;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                n_state = S_CWT;
            end
            S_CWT: begin
                n_n     = cnt_rdata[CNT_W-1:0];
                n_up    = cnt_rdata[CNTW_W-1:CNT_W];
                n_i     = '0;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (r_i < r_n) begin
                    n_state = S_SCHK;
                end else if (r_op == OP_QUERY) begin
                    n_stat  = ST_NOT_FOUND;
                    n_sum   = '0;
                    n_state = S_OUT;
                end else if (r_n >= CNT_W'(MAX_DEGREE)) begin
                    n_full = 1'b1;
                    if (last_add) begin
                        n_stat  = ST_FULL;
                        n_sum   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_phase = 1'b1;
                        n_node  = r_hi;
                        n_id    = r_lo;
                        n_state = S_CRD;
                    end
                end else begin
                    n_j     = r_n;
                    n_state = S_SHRD;
                end
            end
            S_SCHK: begin
                n_i     = r_i + CNT_W'(1);
                n_state = S_SRD;
                if (r_op == OP_INSERT) begin
                    if (ids_rdata == r_id) begin
                        // already present: this add is a no-op
                        if (last_add) begin
                            n_stat  = r_full ? ST_FULL : ST_OK;
                            n_sum   = '0;
                            n_state = S_OUT;
                        end else begin
                            n_phase = 1'b1;
                            n_node  = r_hi;
                            n_id    = r_lo;
                            n_state = S_CRD;
                        end
                    end
                end else if (ids_rdata > r_node) begin
                    if (ids_rdata == r_id) begin
                        n_sum   = {{(SUM_W-DEG_W){1'b0}}, r_rank};
                        n_k     = '0;
                        n_sv    = 1'b0;
                        n_stat  = ST_OK;
                        n_state = S_SUM;
                    end else begin
                        n_rank = r_rank + DEG_W'(1);
                    end
                end
            end
            S_SHRD: begin
                ids_raddr = {r_node, r_j[DEG_W-1:0] - DEG_W'(1)};
                if (r_j != '0) begin
                    n_state = S_SHCHK;
                end else begin
                    ids_we  = 1'b1;
                    n_state = S_CWR;
                end
            end
            S_SHCHK: begin
                ids_we = 1'b1;
                if (ids_rdata > r_id) begin
                    ids_wdata = ids_rdata;
                    n_j       = r_j - CNT_W'(1);
                    n_state   = S_SHRD;
                end else begin
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                cnt_we = 1'b1;
                if (last_add) begin
                    n_stat  = r_full ? ST_FULL : ST_OK;
                    n_sum   = '0;
                    n_state = S_OUT;
                end else begin
                    n_phase = 1'b1;
                    n_node  = r_hi;
                    n_id    = r_lo;
                    n_state = S_CRD;
                end
            end
            S_SUM: begin
                // one counts read issued per cycle, accumulated in the next cycle
                cnt_raddr = r_k;
                if (r_sv) begin
                    n_sum = (sum_add > (SUM_W+1)'(EDGE_MAX)) ? SUM_W'(EDGE_MAX)
                                                              : sum_add[SUM_W-1:0];
                end
                if (r_k < r_lo) begin
                    n_k  = r_k + NODE_W'(1);
                    n_sv = 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_onum   = r_sum[EDGE_W-1:0];
                    n_ost    = r_stat;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_sv     <= n_sv;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_node  <= n_node;
        r_id    <= n_id;
        r_k     <= n_k;
        r_op    <= n_op;
        r_phase <= n_phase;
        r_full  <= n_full;
        r_n     <= n_n;
        r_up    <= n_up;
        r_i     <= n_i;
        r_j     <= n_j;
        r_rank  <= n_rank;
        r_sum   <= n_sum;
        r_stat  <= n_stat;
        r_onum  <= n_onum;
        r_ost   <= n_ost;
    end
endmodule

### hw/rtl/meai_checker.sv
`timescale 1ns / 1ps
module meai_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import meai_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:14] == ST_OK ||
                           m_axis_tdata[15:14] == ST_NOT_FOUND ||
                           m_axis_tdata[15:14] == ST_FULL))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15:14] != ST_OK |-> m_axis_tdata[13:0] == '0)
        else $error("nonzero edge number on failure");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a second item while busy");
endmodule

bind mesh_edge_adjacency_index_unit meai_checker u_meai_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
